/* rtl/core/bgrhsv_pkg.sv */
`default_nettype none
package bgrhsv_pkg;

	localparam int unsigned PIX_W     = 8;
	localparam int unsigned SUM_W     = PIX_W + 1;
	localparam int unsigned N_W       = 11;
	localparam int unsigned DVD_W     = 19;
	localparam int unsigned DVS_W     = 11;
	localparam int unsigned QUO_W     = 8;
	localparam int unsigned DIV_STEPS = QUO_W;

	localparam logic [SUM_W-1:0] FULL_SCALE = 9'd255;

	localparam int unsigned PADDR_W = 3;
	localparam int unsigned PDATA_W = 32;

	localparam logic REG_IDX_MODE = 1'b0;
	localparam logic MODE_HSV     = 1'b0;
	localparam logic MODE_HSL     = 1'b1;

	typedef enum logic [2:0] {
		SEC_RED   = 3'b001,
		SEC_GREEN = 3'b010,
		SEC_BLUE  = 3'b100
	} sector_t;

	typedef struct packed {
		logic             hue_zero;
		logic             sat_zero;
		logic [PIX_W-1:0] bri;
	} side_t;

endpackage
`default_nettype wire

/* rtl/core/bgrhsv_in_if.sv */
`default_nettype none
interface bgrhsv_in_if;
	logic                         valid;
	logic                         ready;
	logic [bgrhsv_pkg::PIX_W-1:0] blue;
	logic [bgrhsv_pkg::PIX_W-1:0] green;
	logic [bgrhsv_pkg::PIX_W-1:0] red;

	modport source (output valid, output blue, output green, output red, input ready);
	modport sink (input valid, input blue, input green, input red, output ready);
endinterface
`default_nettype wire

/* rtl/core/bgrhsv_out_if.sv */
`default_nettype none
interface bgrhsv_out_if;
	logic                         valid;
	logic                         ready;
	logic [bgrhsv_pkg::PIX_W-1:0] hue;
	logic [bgrhsv_pkg::PIX_W-1:0] saturation;
	logic [bgrhsv_pkg::PIX_W-1:0] brightness;

	modport source (output valid, output hue, output saturation, output brightness, input ready);
	modport sink (input valid, input hue, input saturation, input brightness, output ready);
endinterface
`default_nettype wire

/* rtl/core/bgrhsv_div.sv */
`default_nettype none
module bgrhsv_div (
	input  wire logic                         clk,
	input  wire logic                         en,
	input  wire logic [bgrhsv_pkg::DVD_W-1:0] dividend,
	input  wire logic [bgrhsv_pkg::DVS_W-1:0] divisor,
	output logic      [bgrhsv_pkg::QUO_W-1:0] quotient
);

	localparam int unsigned STEPS = bgrhsv_pkg::DIV_STEPS;
	localparam int unsigned DVD_W = bgrhsv_pkg::DVD_W;
	localparam int unsigned DVS_W = bgrhsv_pkg::DVS_W;
	localparam int unsigned QUO_W = bgrhsv_pkg::QUO_W;

	// restoring division, one quotient bit per stage, msb first
	logic [DVD_W-1:0] rem_sd [STEPS-1];
	logic [DVS_W-1:0] dvs_sd [STEPS-1];
	logic [QUO_W-1:0] quo_sd [STEPS];

	genvar k;
	generate
		for (k = 0; k < STEPS; k++) begin : g_step
			localparam int unsigned SH = STEPS - 1 - k;
			logic [DVD_W-1:0] rem_in;
			logic [DVS_W-1:0] dvs_in;
			logic [QUO_W-1:0] quo_in;
			logic [DVD_W:0]   trial;

			if (k == 0) begin : g_first
				assign rem_in = dividend;
				assign dvs_in = divisor;
				assign quo_in = '0;
			end else begin : g_next
				assign rem_in = rem_sd[k-1];
				assign dvs_in = dvs_sd[k-1];
				assign quo_in = quo_sd[k-1];
			end

			assign trial = {1'b0, rem_in} - ((DVD_W+1)'(dvs_in) << SH);

			always_ff @(posedge clk) begin
				if (en) begin
					quo_sd[k] <= {quo_in[QUO_W-2:0], ~trial[DVD_W]};
				end
			end

			if (k < STEPS - 1) begin : g_carry
				always_ff @(posedge clk) begin
					if (en) begin
						rem_sd[k] <= trial[DVD_W] ? rem_in : trial[DVD_W-1:0];
						dvs_sd[k] <= dvs_in;
					end
				end
			end
		end
	endgenerate

	assign quotient = quo_sd[STEPS-1];

endmodule
`default_nettype wire

/* rtl/core/bgr_to_hsv_hsl_pixel_core.sv */
// BGR pixel to HSV / HSL converter, all fields on a 0..255 scale.
// pix_in takes one blue, green, red word per valid/ready handshake;
// pix_out gives one hue, saturation, brightness word for each of them,
// in order. The APB port holds one register, mode (0 = HSV, 1 = HSL),
// at byte address 0; pready is always high and writes take effect at
// the access cycle. Change mode only while no pixel is in flight.
// A pixel accepted on pix_in passes three front stages (max/min,
// sector offset and chroma, scaling by 255), eight restoring divider
// stages, each resolving one quotient bit for hue and saturation in
// parallel, and the output register before it shows on pix_out.
// Throughput: one pixel per clock while pix_out is taken.
// When the receiver holds ready low with a word waiting, the whole pipe
// freezes and pix_in.ready drops in the same cycle; nothing is lost or
// repeated, and the pipe moves on as soon as the word is taken.
// Reset clears mode to HSV and empties the pipe; no clearing pass.
`default_nettype none
module bgr_to_hsv_hsl_pixel_core (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	bgrhsv_in_if.sink                           pix_in,
	bgrhsv_out_if.source                        pix_out,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [bgrhsv_pkg::PADDR_W-1:0] paddr,
	input  wire logic [bgrhsv_pkg::PDATA_W-1:0] pwdata,
	output logic      [bgrhsv_pkg::PDATA_W-1:0] prdata,
	output logic                                pready
);

	localparam int unsigned PIX_W = bgrhsv_pkg::PIX_W;
	localparam int unsigned SUM_W = bgrhsv_pkg::SUM_W;
	localparam int unsigned N_W   = bgrhsv_pkg::N_W;
	localparam int unsigned DVD_W = bgrhsv_pkg::DVD_W;
	localparam int unsigned DVS_W = bgrhsv_pkg::DVS_W;
	localparam int unsigned QUO_W = bgrhsv_pkg::QUO_W;
	localparam int unsigned STEPS = bgrhsv_pkg::DIV_STEPS;

	// config register
	logic mode_q;
	logic reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[bgrhsv_pkg::PADDR_W-1] == bgrhsv_pkg::REG_IDX_MODE);
	assign prdata  = reg_sel ? bgrhsv_pkg::PDATA_W'(mode_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= bgrhsv_pkg::MODE_HSV;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			mode_q <= pwdata[0];
		end
	end

	// global advance: the pipe moves whenever the output word can move
	logic en;
	assign en           = !pix_out.valid || pix_out.ready;
	assign pix_in.ready = en;

	// stage 1: max, min, sector
	logic                    valid_s1;
	logic [PIX_W-1:0]        blu_s1, grn_s1, red_s1, mx_s1, mn_s1;
	bgrhsv_pkg::sector_t     sec_s1;
	logic [PIX_W-1:0]        mx_c, mn_c, mx_bg, mn_bg;
	bgrhsv_pkg::sector_t     sec_c;

	always_comb begin
		mx_bg = (pix_in.blue > pix_in.green) ? pix_in.blue : pix_in.green;
		mn_bg = (pix_in.blue < pix_in.green) ? pix_in.blue : pix_in.green;
		mx_c  = (mx_bg > pix_in.red) ? mx_bg : pix_in.red;
		mn_c  = (mn_bg < pix_in.red) ? mn_bg : pix_in.red;
		priority if (pix_in.blue == mx_c) begin
			sec_c = bgrhsv_pkg::SEC_BLUE;
		end else if (pix_in.green == mx_c) begin
			sec_c = bgrhsv_pkg::SEC_GREEN;
		end else begin
			sec_c = bgrhsv_pkg::SEC_RED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= pix_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			blu_s1 <= pix_in.blue;
			grn_s1 <= pix_in.green;
			red_s1 <= pix_in.red;
			mx_s1  <= mx_c;
			mn_s1  <= mn_c;
			sec_s1 <= sec_c;
		end
	end

	// stage 2: chroma, sector offset, saturation divisor, brightness
	logic                    valid_s2;
	logic [PIX_W-1:0]        c_s2;
	logic [N_W-1:0]          n_s2;
	logic [PIX_W-1:0]        sdvs_s2;
	bgrhsv_pkg::side_t       side_s2;
	logic [PIX_W-1:0]        c_c;
	logic [N_W-1:0]          c2_c, c4_c, c6_c, n_c;
	logic [SUM_W-1:0]        sum_c, dev_c, den9_c;
	logic [PIX_W-1:0]        den_c, sdvs_c;
	bgrhsv_pkg::side_t       side_c;

	always_comb begin
		c_c   = mx_s1 - mn_s1;
		c2_c  = N_W'(c_c) << 1;
		c4_c  = N_W'(c_c) << 2;
		c6_c  = c4_c + c2_c;
		unique case (sec_s1)
			bgrhsv_pkg::SEC_BLUE:  n_c = N_W'(red_s1) + c4_c - N_W'(grn_s1);
			bgrhsv_pkg::SEC_GREEN: n_c = N_W'(blu_s1) + c2_c - N_W'(red_s1);
			bgrhsv_pkg::SEC_RED: begin
				if (grn_s1 >= blu_s1) begin
					n_c = N_W'(grn_s1) - N_W'(blu_s1);
				end else begin
					n_c = N_W'(grn_s1) + c6_c - N_W'(blu_s1);
				end
			end
			default: n_c = '0;
		endcase
		sum_c  = SUM_W'(mx_s1) + SUM_W'(mn_s1);
		dev_c  = (sum_c >= bgrhsv_pkg::FULL_SCALE) ? sum_c - bgrhsv_pkg::FULL_SCALE
		                                           : bgrhsv_pkg::FULL_SCALE - sum_c;
		den9_c = bgrhsv_pkg::FULL_SCALE - dev_c;
		den_c  = den9_c[PIX_W-1:0];
		side_c.hue_zero = (c_c == '0);
		if (mode_q == bgrhsv_pkg::MODE_HSL) begin
			sdvs_c          = den_c;
			side_c.bri      = sum_c[SUM_W-1:1];
			side_c.sat_zero = (c_c == '0) || (den_c == '0);
		end else begin
			sdvs_c          = mx_s1;
			side_c.bri      = mx_s1;
			side_c.sat_zero = (c_c == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s2    <= c_c;
			n_s2    <= n_c;
			sdvs_s2 <= sdvs_c;
			side_s2 <= side_c;
		end
	end

	// stage 3: dividends scaled by 255, divisors
	logic                    valid_s3;
	logic [DVD_W-1:0]        hdvd_s3, sdvd_s3;
	logic [DVS_W-1:0]        hdvs_s3, sdvs_s3;
	bgrhsv_pkg::side_t       side_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hdvd_s3 <= (DVD_W'(n_s2) << PIX_W) - DVD_W'(n_s2);
			sdvd_s3 <= (DVD_W'(c_s2) << PIX_W) - DVD_W'(c_s2);
			hdvs_s3 <= (DVS_W'(c_s2) << 2) + (DVS_W'(c_s2) << 1);
			sdvs_s3 <= DVS_W'(sdvs_s2);
			side_s3 <= side_s2;
		end
	end

	// divider stages
	logic [QUO_W-1:0] hue_quo, sat_quo;

	bgrhsv_div u_hue_div (
		.clk      (clk),
		.en       (en),
		.dividend (hdvd_s3),
		.divisor  (hdvs_s3),
		.quotient (hue_quo)
	);

	bgrhsv_div u_sat_div (
		.clk      (clk),
		.en       (en),
		.dividend (sdvd_s3),
		.divisor  (sdvs_s3),
		.quotient (sat_quo)
	);

	logic              valid_sd [STEPS];
	bgrhsv_pkg::side_t side_sd  [STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < STEPS; i++) begin
				valid_sd[i] <= 1'b0;
			end
		end else if (en) begin
			valid_sd[0] <= valid_s3;
			for (int i = 1; i < STEPS; i++) begin
				valid_sd[i] <= valid_sd[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_sd[0] <= side_s3;
			for (int i = 1; i < STEPS; i++) begin
				side_sd[i] <= side_sd[i-1];
			end
		end
	end

	// output register
	logic             valid_so;
	logic [PIX_W-1:0] hue_so, sat_so, bri_so;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_so <= 1'b0;
		end else if (en) begin
			valid_so <= valid_sd[STEPS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hue_so <= side_sd[STEPS-1].hue_zero ? '0 : PIX_W'(hue_quo);
			sat_so <= side_sd[STEPS-1].sat_zero ? '0 : PIX_W'(sat_quo);
			bri_so <= side_sd[STEPS-1].bri;
		end
	end

	assign pix_out.valid      = valid_so;
	assign pix_out.hue        = hue_so;
	assign pix_out.saturation = sat_so;
	assign pix_out.brightness = bri_so;

`ifndef ASSERT_OFF
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		pix_in.valid && pix_in.ready |=> valid_s1)
		else $error("accepted word did not enter the pipe");

	a_hue_fits: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && !side_s3.hue_zero |-> hdvd_s3 < {hdvs_s3, 8'h00})
		else $error("hue quotient would overflow the divider");

	a_sat_fits: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && !side_s3.sat_zero |-> sdvd_s3 < {sdvs_s3, 8'h00})
		else $error("saturation quotient would overflow the divider");

	a_hsv_black: assert property (@(posedge clk) disable iff (!arst_n)
		pix_out.valid && (mode_q == bgrhsv_pkg::MODE_HSV) && (pix_out.brightness == '0)
		|-> (pix_out.saturation == '0) && (pix_out.hue == '0))
		else $error("black pixel with nonzero hue or saturation");
`endif

endmodule
`default_nettype wire
